[hw/rtl/triangle_tangent_frame_macros.svh]
// Assertion macros for the triangle tangent frame block.
// Included by the top level; depends on nothing else.
`ifndef TRIANGLE_TANGENT_FRAME_MACROS_SVH
`define TRIANGLE_TANGENT_FRAME_MACROS_SVH

// Same-cycle implication, checked on the rising clock, off during reset.
`define TTF_ASSERT_NOW(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked on the rising clock, off during reset.
`define TTF_ASSERT_NEXT(lbl, clk, rstn, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
        else $error(msg);

`endif

[hw/rtl/ttf_pkg.sv]
// Shared types and constants for the triangle tangent frame block.
// Used by ttf_ctrl, ttf_dp and triangle_tangent_frame; depends on nothing.
`default_nettype none
package ttf_pkg;

    localparam int TRI_CORNERS = 3;
    localparam int POS_W       = 24;
    localparam int TEX_W       = 16;
    localparam int EDGE_W      = POS_W + 1;
    localparam int DUV_W       = TEX_W + 1;
    localparam int COMP_W      = 43;
    localparam int MAG_W       = 42;
    localparam int OUT_W       = 16;
    localparam int S_DATA_W    = 104;
    localparam int M_DATA_W    = 96;
    localparam int PROD_STEPS  = 7;
    localparam int ROOT_STEPS  = 32;
    localparam int DIV_STEPS   = 15;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_PROD,
        ST_LOAD,
        ST_NORM,
        ST_SQ,
        ST_RINIT,
        ST_ROOT,
        ST_DINIT,
        ST_DIV,
        ST_EMIT
    } t_state;

    typedef struct packed {
        logic       store_lo;
        logic       corner_sel;
        logic       store_hi;
        logic       prod;
        logic [2:0] step;
        logic       vec;
        logic [1:0] comp;
        logic       mag_load;
        logic       norm_right;
        logic       norm_left;
        logic       sq_acc;
        logic       root_init;
        logic       root_step;
        logic       div_init;
        logic       div_step;
        logic       div_store;
        logic       deg_set;
        logic       out_load;
    } t_cmd;

    typedef struct packed {
        logic vec_zero;
        logic det_zero;
        logic mag_big;
        logic mag_small;
        logic out_free;
    } t_stat;

endpackage
`default_nettype wire

[hw/rtl/ttf_ctrl.sv]
// Sequencer for the triangle tangent frame block.
// Depends on ttf_pkg; drives ttf_dp through t_cmd and reads t_stat.
`default_nettype none
module ttf_ctrl
    import ttf_pkg::*;
(
    input  wire   i_clk,
    input  wire   i_rst_n,
    input  wire   i_in_valid,
    output logic  o_in_ready,
    input  t_stat i_stat,
    output t_cmd  o_cmd
);

    t_state     r_state, n_state;
    logic [4:0] r_cnt, n_cnt;
    logic [1:0] r_corner, n_corner;
    logic       r_vec, n_vec;
    logic [1:0] r_comp, n_comp;
    logic       w_fire;
    logic       w_last_corner;

    assign w_fire        = i_in_valid && (r_state == ST_IDLE);
    assign w_last_corner = (r_corner == 2'(TRI_CORNERS - 1));

    always_comb begin
        n_state  = r_state;
        n_corner = r_corner;
        n_vec    = r_vec;
        n_comp   = r_comp;
        case (r_state)
            ST_IDLE: begin
                if (w_fire) begin
                    if (w_last_corner) begin
                        n_corner = 2'd0;
                        n_state  = ST_PROD;
                    end else begin
                        n_corner = r_corner + 2'd1;
                    end
                end
            end
            ST_PROD: begin
                n_vec = 1'b0;
                if (r_cnt == 5'(PROD_STEPS - 1)) n_state = ST_LOAD;
            end
            ST_LOAD: begin
                n_comp = 2'd0;
                if (i_stat.det_zero || i_stat.vec_zero) n_state = ST_EMIT;
                else n_state = ST_NORM;
            end
            ST_NORM: begin
                if (!i_stat.mag_big && !i_stat.mag_small) n_state = ST_SQ;
            end
            ST_SQ: begin
                if (r_cnt == 5'd2) n_state = ST_RINIT;
            end
            ST_RINIT: n_state = ST_ROOT;
            ST_ROOT: begin
                if (r_cnt == 5'(ROOT_STEPS - 1)) n_state = ST_DINIT;
            end
            ST_DINIT: n_state = ST_DIV;
            ST_DIV: begin
                if (r_cnt == 5'(DIV_STEPS - 1)) begin
                    if (r_comp == 2'd2) begin
                        if (r_vec) begin
                            n_state = ST_EMIT;
                        end else begin
                            n_vec   = 1'b1;
                            n_state = ST_LOAD;
                        end
                    end else begin
                        n_comp  = r_comp + 2'd1;
                        n_state = ST_DINIT;
                    end
                end
            end
            ST_EMIT: begin
                if (i_stat.out_free) n_state = ST_IDLE;
            end
            default: n_state = ST_IDLE;
        endcase
        // restart the step count on every state change
        n_cnt = (n_state != r_state) ? 5'd0 : r_cnt + 5'd1;
    end

    always_comb begin
        o_cmd            = '0;
        o_in_ready       = (r_state == ST_IDLE);
        o_cmd.corner_sel = r_corner[0];
        o_cmd.step       = r_cnt[2:0];
        o_cmd.vec        = r_vec;
        o_cmd.comp       = (r_state == ST_SQ) ? r_cnt[1:0] : r_comp;
        case (r_state)
            ST_IDLE: begin
                o_cmd.store_lo = w_fire && !w_last_corner;
                o_cmd.store_hi = w_fire && w_last_corner;
            end
            ST_PROD:  o_cmd.prod = 1'b1;
            ST_LOAD: begin
                o_cmd.mag_load = 1'b1;
                o_cmd.deg_set  = i_stat.det_zero || i_stat.vec_zero;
            end
            ST_NORM: begin
                o_cmd.norm_right = i_stat.mag_big;
                o_cmd.norm_left  = !i_stat.mag_big && i_stat.mag_small;
            end
            ST_SQ:    o_cmd.sq_acc    = 1'b1;
            ST_RINIT: o_cmd.root_init = 1'b1;
            ST_ROOT:  o_cmd.root_step = 1'b1;
            ST_DINIT: o_cmd.div_init  = 1'b1;
            ST_DIV: begin
                o_cmd.div_step  = 1'b1;
                o_cmd.div_store = (r_cnt == 5'(DIV_STEPS - 1));
            end
            ST_EMIT:  o_cmd.out_load = i_stat.out_free;
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= ST_IDLE;
            r_cnt    <= 5'd0;
            r_corner <= 2'd0;
            r_vec    <= 1'b0;
            r_comp   <= 2'd0;
        end else begin
            r_state  <= n_state;
            r_cnt    <= n_cnt;
            r_corner <= n_corner;
            r_vec    <= n_vec;
            r_comp   <= n_comp;
        end
    end

endmodule
`default_nettype wire

[hw/rtl/ttf_dp.sv]
// Datapath of the triangle tangent frame block: corner store, products,
// normalize shifter, square root and divider units, output register. Uses ttf_pkg.
`default_nettype none
module ttf_dp
    import ttf_pkg::*;
(
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  t_cmd                 i_cmd,
    input  wire [S_DATA_W-1:0]   i_data,
    input  wire                  i_out_ready,
    output t_stat                o_stat,
    output logic                 o_out_valid,
    output logic [M_DATA_W-1:0]  o_out_data,
    output logic                 o_out_deg
);

    logic signed [POS_W-1:0]  w_p [3];
    logic signed [TEX_W-1:0]  w_u, w_v;

    logic signed [POS_W-1:0]  r_p0 [3];
    logic signed [POS_W-1:0]  r_p1 [3];
    logic signed [TEX_W-1:0]  r_u0, r_v0, r_u1, r_v1;

    logic signed [EDGE_W-1:0] r_e1 [3];
    logic signed [EDGE_W-1:0] r_e2 [3];
    logic signed [DUV_W-1:0]  r_d1u, r_d1v, r_d2u, r_d2v;

    logic signed [COMP_W-1:0] r_tan [3];
    logic signed [COMP_W-1:0] r_bit [3];
    logic                     r_det_neg, r_det_zero;

    logic [MAG_W-1:0]         r_mag [3];
    logic [61:0]              r_acc;
    logic [61:0]              r_x;
    logic [62:0]              r_r, r_b;
    logic [30:0]              r_rem;
    logic [DIV_STEPS-1:0]     r_nlo, r_quo;
    logic signed [OUT_W-1:0]  r_tn [3];
    logic signed [OUT_W-1:0]  r_bn [3];
    logic                     r_deg;
    logic                     r_out_valid;
    logic [M_DATA_W-1:0]      r_out_data;
    logic                     r_out_deg;

    logic signed [DUV_W-1:0]  w_ma, w_mc;
    logic signed [EDGE_W-1:0] w_mb, w_md;
    logic signed [41:0]       w_pa, w_pc;
    logic signed [COMP_W-1:0] w_diff;
    logic signed [COMP_W-1:0] w_sel [3];
    logic [COMP_W-1:0]        w_abs [3];
    logic [1:0]               w_ix;
    logic [59:0]              w_sq;
    logic [62:0]              w_rb;
    logic                     w_rge;
    logic [30:0]              w_len;
    logic [44:0]              w_num;
    logic [31:0]              w_t, w_tsub;
    logic                     w_qge;
    logic [DIV_STEPS-1:0]     w_q;
    logic                     w_neg;
    logic signed [OUT_W-1:0]  w_res;
    logic                     w_out_free;

    assign w_p[0] = i_data[23:0];
    assign w_p[1] = i_data[47:24];
    assign w_p[2] = i_data[71:48];
    assign w_u    = i_data[87:72];
    assign w_v    = i_data[103:88];

    // operand select: tangent, bitangent components, then the UV determinant
    assign w_ix = (i_cmd.step >= 3'd3) ? 2'(i_cmd.step - 3'd3) : i_cmd.step[1:0];
    always_comb begin
        if (i_cmd.step == 3'(PROD_STEPS - 1)) begin
            w_ma = r_d1u;
            w_mb = EDGE_W'(r_d2v);
            w_mc = r_d2u;
            w_md = EDGE_W'(r_d1v);
        end else if (i_cmd.step >= 3'd3) begin
            w_ma = r_d1u;
            w_mb = r_e2[w_ix];
            w_mc = r_d2u;
            w_md = r_e1[w_ix];
        end else begin
            w_ma = r_d2v;
            w_mb = r_e1[w_ix];
            w_mc = r_d1v;
            w_md = r_e2[w_ix];
        end
    end
    assign w_pa   = w_ma * w_mb;
    assign w_pc   = w_mc * w_md;
    assign w_diff = {w_pa[41], w_pa} - {w_pc[41], w_pc};

    always_comb begin
        for (int i = 0; i < 3; i++) begin
            w_sel[i] = i_cmd.vec ? r_bit[i] : r_tan[i];
            w_abs[i] = w_sel[i][COMP_W-1] ? COMP_W'(-w_sel[i]) : COMP_W'(w_sel[i]);
        end
    end

    assign w_sq  = r_mag[i_cmd.comp][29:0] * r_mag[i_cmd.comp][29:0];
    assign w_rb  = r_r + r_b;
    assign w_rge = ({1'b0, r_x} >= w_rb);
    assign w_len = r_r[30:0];

    assign w_num  = {1'b0, r_mag[i_cmd.comp][29:0], 14'd0} + 45'(w_len >> 1);
    assign w_t    = {r_rem, r_nlo[DIV_STEPS-1]};
    assign w_qge  = (w_t >= {1'b0, w_len});
    assign w_tsub = w_t - {1'b0, w_len};
    assign w_q    = {r_quo[DIV_STEPS-2:0], w_qge};
    assign w_neg  = w_sel[i_cmd.comp][COMP_W-1] ^ r_det_neg;
    assign w_res  = w_neg ? -$signed({1'b0, w_q}) : $signed({1'b0, w_q});

    assign w_out_free = !r_out_valid || i_out_ready;

    always_comb begin
        o_stat.vec_zero  = (w_sel[0] == '0) && (w_sel[1] == '0) && (w_sel[2] == '0);
        o_stat.det_zero  = r_det_zero;
        o_stat.mag_big   = (r_mag[0][MAG_W-1:30] != '0) || (r_mag[1][MAG_W-1:30] != '0)
                        || (r_mag[2][MAG_W-1:30] != '0);
        o_stat.mag_small = (r_mag[0][MAG_W-1:29] == '0) && (r_mag[1][MAG_W-1:29] == '0)
                        && (r_mag[2][MAG_W-1:29] == '0);
        o_stat.out_free  = w_out_free;
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_cmd.store_lo) begin
            if (i_cmd.corner_sel) begin
                r_p1 <= w_p;
                r_u1 <= w_u;
                r_v1 <= w_v;
            end else begin
                r_p0 <= w_p;
                r_u0 <= w_u;
                r_v0 <= w_v;
            end
        end
        if (i_cmd.store_hi) begin
            for (int i = 0; i < 3; i++) begin
                r_e1[i] <= EDGE_W'(r_p1[i]) - EDGE_W'(r_p0[i]);
                r_e2[i] <= EDGE_W'(w_p[i]) - EDGE_W'(r_p0[i]);
            end
            r_d1u <= DUV_W'(r_u1) - DUV_W'(r_u0);
            r_d1v <= DUV_W'(r_v1) - DUV_W'(r_v0);
            r_d2u <= DUV_W'(w_u) - DUV_W'(r_u0);
            r_d2v <= DUV_W'(w_v) - DUV_W'(r_v0);
        end
        if (i_cmd.prod) begin
            if (i_cmd.step == 3'(PROD_STEPS - 1)) begin
                r_det_neg  <= w_diff[COMP_W-1];
                r_det_zero <= (w_diff == '0);
            end else if (i_cmd.step >= 3'd3) begin
                r_bit[w_ix] <= w_diff;
            end else begin
                r_tan[w_ix] <= w_diff;
            end
        end
        if (i_cmd.mag_load) begin
            for (int i = 0; i < 3; i++) r_mag[i] <= w_abs[i][MAG_W-1:0];
            r_acc <= '0;
        end
        if (i_cmd.norm_right) begin
            for (int i = 0; i < 3; i++) r_mag[i] <= r_mag[i] >> 1;
        end
        if (i_cmd.norm_left) begin
            for (int i = 0; i < 3; i++) r_mag[i] <= r_mag[i] << 1;
        end
        if (i_cmd.sq_acc) r_acc <= r_acc + 62'(w_sq);
        if (i_cmd.root_init) begin
            r_x <= r_acc;
            r_r <= '0;
            r_b <= 63'(1) << 62;
        end
        if (i_cmd.root_step) begin
            if (w_rge) begin
                r_x <= r_x - w_rb[61:0];
                r_r <= (r_r >> 1) + r_b;
            end else begin
                r_r <= r_r >> 1;
            end
            r_b <= r_b >> 2;
        end
        if (i_cmd.div_init) begin
            r_rem <= {1'b0, w_num[44:15]};
            r_nlo <= w_num[14:0];
            r_quo <= '0;
        end
        if (i_cmd.div_step) begin
            r_rem <= w_qge ? w_tsub[30:0] : w_t[30:0];
            r_nlo <= r_nlo << 1;
            r_quo <= w_q;
        end
        if (i_cmd.div_store) begin
            if (i_cmd.vec) r_bn[i_cmd.comp] <= w_res;
            else           r_tn[i_cmd.comp] <= w_res;
        end
        if (i_cmd.out_load) begin
            r_out_deg  <= r_deg;
            r_out_data <= r_deg ? '0 : {r_bn[2], r_bn[1], r_bn[0], r_tn[2], r_tn[1], r_tn[0]};
        end
    end

    // control flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_deg       <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (i_cmd.store_hi)     r_deg <= 1'b0;
            else if (i_cmd.deg_set) r_deg <= 1'b1;
            if (i_cmd.out_load)     r_out_valid <= 1'b1;
            else if (i_out_ready)   r_out_valid <= 1'b0;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out_data;
    assign o_out_deg   = r_out_deg;

endmodule
`default_nettype wire

[hw/rtl/triangle_tangent_frame.sv]
// Triangle tangent frame: takes one triangle corner per input item (position
// Q12.12, texture coordinate Q4.12) and, on every third corner, returns one
// item with the unit tangent and unit bitangent in Q1.14 plus a degenerate flag
// (set, with all vector fields zero, when the UV determinant is zero or either
// vector has zero length). The third corner of a triangle starts a sequence
// that runs on one shared set of units: the tangent, bitangent and determinant
// products, then for each of the two vectors a load, a normalizing shifter
// that moves one bit per cycle (up to 29 shifts, then a step that finds the
// range reached), one squaring multiplier for the three components, a setup
// step and a bit-pair square root, and three restoring divisions, and finally
// a load of the output register once it is free. A triangle found degenerate
// before normalizing ends its sequence early. Input is not taken while a
// triangle is in work. The result sits in an output register, so the next
// triangle's first corners are taken while it waits to be read.
// Depends on ttf_pkg, ttf_ctrl, ttf_dp and triangle_tangent_frame_macros.svh.
`default_nettype none
`include "triangle_tangent_frame_macros.svh"
module triangle_tangent_frame
    import ttf_pkg::*;
(
    input  wire                  i_clk,
    input  wire                  i_rst_n,
    input  wire                  s_axis_tvalid,
    output logic                 s_axis_tready,
    // position_x, position_y, position_z, tex_u, tex_v
    input  wire [S_DATA_W-1:0]   s_axis_tdata,
    output logic                 m_axis_tvalid,
    input  wire                  m_axis_tready,
    // tangent_x, tangent_y, tangent_z, bitangent_x, bitangent_y, bitangent_z
    output logic [M_DATA_W-1:0]  m_axis_tdata,
    // degenerate
    output logic                 m_axis_tuser
);

    t_cmd  w_cmd;
    t_stat w_stat;

    // sequence corners and the per-triangle arithmetic
    ttf_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (s_axis_tvalid),
        .o_in_ready (s_axis_tready),
        .i_stat     (w_stat),
        .o_cmd      (w_cmd)
    );

    // hold corners, compute the frame and keep the result item
    ttf_dp u_dp (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cmd       (w_cmd),
        .i_data      (s_axis_tdata),
        .i_out_ready (m_axis_tready),
        .o_stat      (w_stat),
        .o_out_valid (m_axis_tvalid),
        .o_out_data  (m_axis_tdata),
        .o_out_deg   (m_axis_tuser)
    );

    // a degenerate item carries zero vectors
    `TTF_ASSERT_NOW(a_deg_zero, i_clk, i_rst_n, m_axis_tvalid && m_axis_tuser, m_axis_tdata == '0, "degenerate item with nonzero vectors")

    // the tangent x component stays within plus or minus one in Q1.14
    `TTF_ASSERT_NOW(a_unit_range, i_clk, i_rst_n, m_axis_tvalid, ($signed(m_axis_tdata[15:0]) <= 16'sd16384) && ($signed(m_axis_tdata[15:0]) >= -16'sd16384), "tangent x out of unit range")

    // a third corner starts work, so input is closed the next cycle
    `TTF_ASSERT_NEXT(a_busy_after_third, i_clk, i_rst_n, s_axis_tvalid && s_axis_tready && w_cmd.store_hi, !s_axis_tready, "input open right after a third corner")

endmodule
`default_nettype wire

[sim/triangle_tangent_frame_tb.sv]
// Testbench for triangle_tangent_frame: streams triangle corners, predicts each
// triangle's unit tangent frame in fixed point and checks every result item.
// Depends on ttf_pkg and the triangle_tangent_frame RTL.
`default_nettype none

class frame_scoreboard;
    typedef struct {
        logic [15:0] tan [3];
        logic [15:0] bit_v [3];
        logic        deg;
    } frame_t;

    frame_t      pending_frames[$];
    int          corner_idx;
    longint      held_pos[2][3];
    longint      held_uv[2][2];
    int          errors;
    int          frames_seen;
    int          degenerate_seen;

    function void clear();
        corner_idx = 0;
        errors = 0;
        frames_seen = 0;
        degenerate_seen = 0;
        pending_frames.delete();
    endfunction

    static function longint root_floor(longint unsigned x);
        longint unsigned r, b;
        r = 0;
        b = 64'd1 << 62;
        while (b > x) b >>= 2;
        while (b != 0) begin
            if (x >= r + b) begin
                x -= r + b;
                r = (r >> 1) + b;
            end else begin
                r >>= 1;
            end
            b >>= 2;
        end
        return longint'(r);
    endfunction

    // Scale to unit length in Q1.14; returns 0 for a zero vector.
    static function bit unit_vec(longint c[3], output logic [15:0] q[3]);
        longint unsigned m[3], mx, s, len, r;
        mx = 0;
        s = 0;
        for (int i = 0; i < 3; i++) begin
            m[i] = c[i] < 0 ? -c[i] : c[i];
            if (m[i] > mx) mx = m[i];
        end
        if (mx == 0) return 0;
        while (mx >= (64'd1 << 30)) begin
            for (int i = 0; i < 3; i++) m[i] >>= 1;
            mx >>= 1;
        end
        while (mx < (64'd1 << 29)) begin
            for (int i = 0; i < 3; i++) m[i] <<= 1;
            mx <<= 1;
        end
        for (int i = 0; i < 3; i++) s += m[i] * m[i];
        len = root_floor(s);
        for (int i = 0; i < 3; i++) begin
            r = (m[i] * 16384 + (len >> 1)) / len;
            q[i] = c[i] < 0 ? 16'(-longint'(r)) : 16'(r);
        end
        return 1;
    endfunction

    // Note an accepted corner; the third one queues a predicted frame.
    function void note_corner(logic [103:0] d);
        longint p[3], u, v, e1[3], e2[3], d1u, d1v, d2u, d2v, det;
        longint t[3], b[3];
        frame_t f;
        bit ok;
        for (int i = 0; i < 3; i++) p[i] = longint'($signed(d[24*i +: 24]));
        u = longint'($signed(d[87:72]));
        v = longint'($signed(d[103:88]));
        if (corner_idx < 2) begin
            for (int i = 0; i < 3; i++) held_pos[corner_idx][i] = p[i];
            held_uv[corner_idx][0] = u;
            held_uv[corner_idx][1] = v;
            corner_idx++;
            return;
        end
        corner_idx = 0;
        for (int i = 0; i < 3; i++) begin
            e1[i] = held_pos[1][i] - held_pos[0][i];
            e2[i] = p[i] - held_pos[0][i];
        end
        d1u = held_uv[1][0] - held_uv[0][0];
        d1v = held_uv[1][1] - held_uv[0][1];
        d2u = u - held_uv[0][0];
        d2v = v - held_uv[0][1];
        det = d1u * d2v - d2u * d1v;
        for (int i = 0; i < 3; i++) begin
            t[i] = d2v * e1[i] - d1v * e2[i];
            b[i] = d1u * e2[i] - d2u * e1[i];
            if (det < 0) begin
                t[i] = -t[i];
                b[i] = -b[i];
            end
        end
        ok = det != 0;
        if (ok) ok = unit_vec(t, f.tan);
        if (ok) ok = unit_vec(b, f.bit_v);
        if (!ok) begin
            for (int i = 0; i < 3; i++) begin
                f.tan[i] = '0;
                f.bit_v[i] = '0;
            end
        end
        f.deg = !ok;
        pending_frames = {pending_frames, f};
    endfunction

    function void check_frame(logic [95:0] d, logic deg);
        frame_t f;
        frames_seen++;
        if (deg) degenerate_seen++;
        if (pending_frames.size() == 0) begin
            $display("%0t: unexpected frame %h deg %b", $time, d, deg);
            errors++;
            return;
        end
        f = pending_frames.pop_front();
        for (int i = 0; i < 3; i++) begin
            if (d[16*i +: 16] !== f.tan[i]) begin
                $display("%0t: tangent[%0d] expected %h actual %h",
                         $time, i, f.tan[i], d[16*i +: 16]);
                errors++;
            end
            if (d[48 + 16*i +: 16] !== f.bit_v[i]) begin
                $display("%0t: bitangent[%0d] expected %h actual %h",
                         $time, i, f.bit_v[i], d[48 + 16*i +: 16]);
                errors++;
            end
        end
        if (deg !== f.deg) begin
            $display("%0t: degenerate expected %b actual %b", $time, f.deg, deg);
            errors++;
        end
    endfunction
endclass

module triangle_tangent_frame_tb
    import ttf_pkg::*;
();

    localparam int RANDOM_CORNERS = 1600;
    localparam longint CYCLE_LIMIT = 64'd4_000_000;

    logic                i_clk;
    logic                i_rst_n;
    logic                s_axis_tvalid;
    logic                s_axis_tready;
    logic [S_DATA_W-1:0] s_axis_tdata;
    logic                m_axis_tvalid;
    logic                m_axis_tready;
    logic [M_DATA_W-1:0] m_axis_tdata;
    logic                m_axis_tuser;

    frame_scoreboard frames;
    longint          cycle_count;
    int              corners_sent;
    bit              stall_mode;

    triangle_tangent_frame i_dut (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    initial begin
        i_clk = 1'b0;
        frames = new();
        frames.clear();
    end

    always begin
        #10 i_clk = 1'b1;
        #10 i_clk = 1'b0;
    end

    // Sample handshakes on the edge; inputs change only by nonblocking writes.
    always @(posedge i_clk) begin
        if (i_rst_n) begin
            if (s_axis_tvalid && s_axis_tready) frames.note_corner(s_axis_tdata);
            if (m_axis_tvalid && m_axis_tready) frames.check_frame(m_axis_tdata, m_axis_tuser);
        end
    end

    // Receiver: alternate between never stalling and stalling on a random pattern.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            m_axis_tready <= 1'b0;
        end else begin
            if ($urandom_range(0, 199) == 0) stall_mode <= ~stall_mode;
            m_axis_tready <= stall_mode ? ($urandom_range(0, 3) == 0) : 1'b1;
        end
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count > CYCLE_LIMIT) begin
            $display("triangle_tangent_frame_tb: done, errors");
            $finish;
        end
    end

    // Hold one corner on the bus until it is taken.
    task automatic send_corner(logic [23:0] x, logic [23:0] y, logic [23:0] z,
                               logic [15:0] u, logic [15:0] v);
        s_axis_tdata  <= {v, u, z, y, x};
        s_axis_tvalid <= 1'b1;
        do @(posedge i_clk); while (!s_axis_tready);
        corners_sent++;
    endtask

    // Random gap after a burst; the valid drops only when no item follows at once.
    task automatic maybe_gap();
        int gap;
        if ($urandom_range(0, 5) != 0) return;
        gap = $urandom_range(1, 12);
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge i_clk);
    endtask

    task automatic send_random_corner(int flavor);
        logic [23:0] p[3];
        logic [15:0] t[2];
        for (int i = 0; i < 3; i++) begin
            case (flavor)
                0: p[i] = 24'($urandom);
                1: p[i] = 24'($signed($urandom_range(0, 64)) - 32);
                default: p[i] = $urandom_range(0, 1) ? 24'h7FFFFF : 24'h800000;
            endcase
        end
        for (int i = 0; i < 2; i++) begin
            case (flavor)
                0: t[i] = 16'($urandom);
                1: t[i] = 16'($urandom_range(0, 8));
                default: t[i] = $urandom_range(0, 1) ? 16'h7FFF : 16'h8000;
            endcase
        end
        send_corner(p[0], p[1], p[2], t[0], t[1]);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        while (frames.pending_frames.size() != 0) @(posedge i_clk);
        repeat (300) @(posedge i_clk);
    endtask

    initial begin
        i_rst_n       <= 1'b0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        cycle_count   = 0;
        corners_sent  = 0;
        stall_mode    = 1'b0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Ordinary right-angle triangle with a clean UV mapping.
        send_corner(24'd0, 24'd0, 24'd0, 16'd0, 16'd0);
        send_corner(24'd4096, 24'd0, 24'd0, 16'd4096, 16'd0);
        send_corner(24'd0, 24'd4096, 24'd0, 16'd0, 16'd4096);
        // Mirrored UVs: negative determinant flips both vectors.
        send_corner(24'd0, 24'd0, 24'd0, 16'd0, 16'd0);
        send_corner(24'd4096, 24'd0, 24'd0, -16'sd4096, 16'd0);
        send_corner(24'd0, 24'd4096, 24'd0, 16'd0, 16'd4096);
        // Zero determinant: all corners share one UV.
        send_corner(24'd5, 24'd7, 24'd9, 16'd100, 16'd100);
        send_corner(24'd50, 24'd1, 24'd3, 16'd100, 16'd100);
        send_corner(24'd2, 24'd70, 24'd30, 16'd100, 16'd100);
        // Zero-length vectors: all positions equal, UVs non-degenerate.
        send_corner(24'd77, 24'd77, 24'd77, 16'd0, 16'd0);
        send_corner(24'd77, 24'd77, 24'd77, 16'd1, 16'd0);
        send_corner(24'd77, 24'd77, 24'd77, 16'd0, 16'd1);
        // Field extremes: largest spans in position and UV.
        send_corner(24'h800000, 24'h800000, 24'h800000, 16'h8000, 16'h8000);
        send_corner(24'h7FFFFF, 24'h800000, 24'h7FFFFF, 16'h7FFF, 16'h8000);
        send_corner(24'h800000, 24'h7FFFFF, 24'h7FFFFF, 16'h8000, 16'h7FFF);
        // Tiny spans need the full left shift in normalization.
        send_corner(24'd0, 24'd0, 24'd0, 16'd0, 16'd0);
        send_corner(24'd1, 24'd0, 24'd0, 16'd1, 16'd0);
        send_corner(24'd0, 24'd0, 24'd1, 16'd0, 16'd1);
        // Pause until every frame has come back.
        drain();

        // Mostly full-range triangles, some tiny or extreme ones.
        while (corners_sent < 18 + RANDOM_CORNERS) begin
            int flavor;
            int pick;
            pick = $urandom_range(0, 9);
            flavor = pick < 7 ? 0 : (pick < 9 ? 1 : 2);
            for (int k = 0; k < 3; k++) begin
                send_random_corner(flavor);
                maybe_gap();
            end
        end
        drain();

        $display("Sent %0d corners; checked %0d frames, %0d of them degenerate.",
                 corners_sent, frames.frames_seen, frames.degenerate_seen);
        if (frames.errors == 0 && frames.pending_frames.size() == 0) begin
            $display("triangle_tangent_frame_tb: done, clean");
        end else begin
            $display("triangle_tangent_frame_tb: done, errors");
        end
        $finish;
    end
endmodule

`default_nettype wire

[sim.f]
+incdir+hw/rtl
hw/rtl/ttf_pkg.sv
hw/rtl/ttf_ctrl.sv
hw/rtl/ttf_dp.sv
hw/rtl/triangle_tangent_frame.sv
sim/triangle_tangent_frame_tb.sv
